@@ src/rvdec_pkg.sv @@
`timescale 1ns / 1ps
// Package for the RV32IM instruction decoder: opcode constants, mnemonic codes
// and field widths. No dependencies; used by the interfaces and the top level.
package rvdec_pkg;

    localparam int unsigned INSTR_W = 32;
    localparam int unsigned INDEX_W = 30;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned MNEM_W  = 6;
    localparam int unsigned REG_W   = 5;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0f;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    typedef enum logic [MNEM_W-1:0] {
        MN_LUI    = 6'd0,  MN_AUIPC  = 6'd1,  MN_JAL    = 6'd2,  MN_JALR   = 6'd3,
        MN_BEQ    = 6'd4,  MN_BNE    = 6'd5,  MN_BLT    = 6'd6,  MN_BGE    = 6'd7,
        MN_BLTU   = 6'd8,  MN_BGEU   = 6'd9,
        MN_LB     = 6'd10, MN_LH     = 6'd11, MN_LW     = 6'd12, MN_LBU    = 6'd13,
        MN_LHU    = 6'd14,
        MN_SB     = 6'd15, MN_SH     = 6'd16, MN_SW     = 6'd17,
        MN_ADDI   = 6'd18, MN_SLTI   = 6'd19, MN_SLTIU  = 6'd20, MN_XORI   = 6'd21,
        MN_ORI    = 6'd22, MN_ANDI   = 6'd23, MN_SLLI   = 6'd24, MN_SRLI   = 6'd25,
        MN_SRAI   = 6'd26,
        MN_ADD    = 6'd27, MN_SUB    = 6'd28, MN_SLL    = 6'd29, MN_SLT    = 6'd30,
        MN_SLTU   = 6'd31, MN_XOR    = 6'd32, MN_SRL    = 6'd33, MN_SRA    = 6'd34,
        MN_OR     = 6'd35, MN_AND    = 6'd36,
        MN_MUL    = 6'd37, MN_MULH   = 6'd38, MN_MULHSU = 6'd39, MN_MULHU  = 6'd40,
        MN_DIV    = 6'd41, MN_DIVU   = 6'd42, MN_REM    = 6'd43, MN_REMU   = 6'd44,
        MN_FENCE  = 6'd45, MN_FENCEI = 6'd46, MN_ECALL  = 6'd47, MN_EBREAK = 6'd48,
        MN_CSRRW  = 6'd49, MN_CSRRS  = 6'd50, MN_CSRRC  = 6'd51, MN_CSRRWI = 6'd52,
        MN_CSRRSI = 6'd53, MN_CSRRCI = 6'd54
    } t_mnemonic;

endpackage

@@ src/rvdec_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the decoder: instruction requests in,
// decoded results out. Depends on rvdec_pkg for the field widths.
interface rvdec_req_if;
    logic                             valid;
    logic                             ready;
    logic [rvdec_pkg::INSTR_W-1:0]    instr_word;
    logic [rvdec_pkg::INDEX_W-1:0]    word_index;

    modport source (output valid, output instr_word, output word_index, input ready);
    modport sink   (input valid, input instr_word, input word_index, output ready);
endinterface

interface rvdec_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [rvdec_pkg::MNEM_W-1:0]     mnemonic;
    logic                             is_valid;
    logic [rvdec_pkg::REG_W-1:0]      dest_reg;
    logic [rvdec_pkg::REG_W-1:0]      src1_reg;
    logic [rvdec_pkg::REG_W-1:0]      src2_reg;
    logic signed [31:0]               immediate;
    logic                             has_target;
    logic [rvdec_pkg::ADDR_W-1:0]     target_addr;

    modport source (output valid, output mnemonic, output is_valid, output dest_reg,
                    output src1_reg, output src2_reg, output immediate,
                    output has_target, output target_addr, input ready);
    modport sink   (input valid, input mnemonic, input is_valid, input dest_reg,
                    input src1_reg, input src2_reg, input immediate,
                    input has_target, input target_addr, output ready);
endinterface

@@ src/rv32im_instruction_decoder_top.sv @@
`timescale 1ns / 1ps
// RV32IM instruction decoder top level. Depends on rvdec_pkg and the
// channel interfaces in rvdec_if.sv.
//
// Decodes one RV32IM instruction word per request into a mnemonic code,
// register numbers, immediate and, for jal and conditional branches, the
// absolute target text_base + 4 * word_index + offset (modulo 2^32). The word
// address text_base + 4 * word_index is formed as a request enters the input
// register; decode and the target add sit between the input register and the
// result register. Throughput is one request per cycle while no result is
// stalled. While a result is stalled the result register holds, the input
// register takes one more request if it is empty and then holds too, so
// i_req.ready drops once two requests wait inside.
// Words that encode no known mnemonic return all-zero fields with is_valid
// low. text_base is written through i_cfg_we and i_cfg_wdata and should only
// change while no request is in flight.
module rv32im_instruction_decoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rvdec_pkg::ADDR_W-1:0]  i_cfg_wdata,
    rvdec_req_if.sink                     i_req,
    rvdec_rsp_if.source                   o_rsp
);

    logic [rvdec_pkg::ADDR_W-1:0]   r_text_base;

    logic                           r_in_valid;
    logic [rvdec_pkg::INSTR_W-1:0]  r_instr;
    logic [rvdec_pkg::ADDR_W-1:0]   r_pc;

    logic                           r_out_valid;
    rvdec_pkg::t_mnemonic           r_mnemonic;
    logic                           r_is_valid;
    logic [rvdec_pkg::REG_W-1:0]    r_dest;
    logic [rvdec_pkg::REG_W-1:0]    r_src1;
    logic [rvdec_pkg::REG_W-1:0]    r_src2;
    logic [31:0]                    r_imm;
    logic                           r_has_tgt;
    logic [rvdec_pkg::ADDR_W-1:0]   r_tgt;

    logic                           out_en;
    logic                           in_en;

    rvdec_pkg::t_mnemonic           n_mnemonic;
    logic                           n_is_valid;
    logic [rvdec_pkg::REG_W-1:0]    n_dest;
    logic [rvdec_pkg::REG_W-1:0]    n_src1;
    logic [rvdec_pkg::REG_W-1:0]    n_src2;
    logic [31:0]                    n_imm;
    logic                           n_has_tgt;
    logic [rvdec_pkg::ADDR_W-1:0]   n_tgt;

    logic [6:0]                     opc;
    logic [4:0]                     rd;
    logic [2:0]                     f3;
    logic [4:0]                     rs1;
    logic [4:0]                     rs2;
    logic [6:0]                     f7;
    logic [31:0]                    imm_i;
    logic [31:0]                    imm_s;
    logic [31:0]                    imm_b;
    logic [31:0]                    imm_j;

    // Each stage advances when the stage after it can take its contents.
    assign out_en      = !r_out_valid || o_rsp.ready;
    assign in_en       = !r_in_valid || out_en;
    assign i_req.ready = in_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_base <= '0;
        end else if (i_cfg_we) begin
            r_text_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_en) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en && i_req.valid) begin
            r_instr <= i_req.instr_word;
            r_pc    <= r_text_base + {i_req.word_index, 2'b00};
        end
    end

    assign opc   = r_instr[6:0];
    assign rd    = r_instr[11:7];
    assign f3    = r_instr[14:12];
    assign rs1   = r_instr[19:15];
    assign rs2   = r_instr[24:20];
    assign f7    = r_instr[31:25];
    assign imm_i = {{20{r_instr[31]}}, r_instr[31:20]};
    assign imm_s = {{20{r_instr[31]}}, r_instr[31:25], r_instr[11:7]};
    assign imm_b = {{19{r_instr[31]}}, r_instr[31], r_instr[7], r_instr[30:25],
                    r_instr[11:8], 1'b0};
    assign imm_j = {{11{r_instr[31]}}, r_instr[31], r_instr[19:12], r_instr[20],
                    r_instr[30:21], 1'b0};

    always_comb begin
        n_mnemonic = rvdec_pkg::MN_LUI;
        n_is_valid = 1'b0;
        n_dest     = '0;
        n_src1     = '0;
        n_src2     = '0;
        n_imm      = '0;
        n_has_tgt  = 1'b0;
        n_tgt      = '0;

        unique case (opc)
            rvdec_pkg::OPC_LUI, rvdec_pkg::OPC_AUIPC: begin
                n_is_valid = 1'b1;
                n_mnemonic = (opc == rvdec_pkg::OPC_LUI) ? rvdec_pkg::MN_LUI
                                                         : rvdec_pkg::MN_AUIPC;
                n_dest     = rd;
                n_imm      = {12'b0, r_instr[31:12]};
            end
            rvdec_pkg::OPC_JAL: begin
                n_is_valid = 1'b1;
                n_mnemonic = rvdec_pkg::MN_JAL;
                n_dest     = rd;
                n_imm      = imm_j;
                n_has_tgt  = 1'b1;
            end
            rvdec_pkg::OPC_JALR: begin
                n_is_valid = (f3 == 3'd0);
                n_mnemonic = rvdec_pkg::MN_JALR;
                n_dest     = rd;
                n_src1     = rs1;
                n_imm      = imm_i;
            end
            rvdec_pkg::OPC_BRANCH: begin
                n_is_valid = 1'b1;
                n_src1     = rs1;
                n_src2     = rs2;
                n_imm      = imm_b;
                n_has_tgt  = 1'b1;
                unique case (f3)
                    3'd0:    n_mnemonic = rvdec_pkg::MN_BEQ;
                    3'd1:    n_mnemonic = rvdec_pkg::MN_BNE;
                    3'd4:    n_mnemonic = rvdec_pkg::MN_BLT;
                    3'd5:    n_mnemonic = rvdec_pkg::MN_BGE;
                    3'd6:    n_mnemonic = rvdec_pkg::MN_BLTU;
                    3'd7:    n_mnemonic = rvdec_pkg::MN_BGEU;
                    default: n_is_valid = 1'b0;
                endcase
            end
            rvdec_pkg::OPC_LOAD: begin
                n_is_valid = 1'b1;
                n_dest     = rd;
                n_src1     = rs1;
                n_imm      = imm_i;
                unique case (f3)
                    3'd0:    n_mnemonic = rvdec_pkg::MN_LB;
                    3'd1:    n_mnemonic = rvdec_pkg::MN_LH;
                    3'd2:    n_mnemonic = rvdec_pkg::MN_LW;
                    3'd4:    n_mnemonic = rvdec_pkg::MN_LBU;
                    3'd5:    n_mnemonic = rvdec_pkg::MN_LHU;
                    default: n_is_valid = 1'b0;
                endcase
            end
            rvdec_pkg::OPC_STORE: begin
                n_is_valid = 1'b1;
                n_src1     = rs1;
                n_src2     = rs2;
                n_imm      = imm_s;
                unique case (f3)
                    3'd0:    n_mnemonic = rvdec_pkg::MN_SB;
                    3'd1:    n_mnemonic = rvdec_pkg::MN_SH;
                    3'd2:    n_mnemonic = rvdec_pkg::MN_SW;
                    default: n_is_valid = 1'b0;
                endcase
            end
            rvdec_pkg::OPC_OPIMM: begin
                n_is_valid = 1'b1;
                n_dest     = rd;
                n_src1     = rs1;
                n_imm      = imm_i;
                unique case (f3)
                    3'd0: n_mnemonic = rvdec_pkg::MN_ADDI;
                    3'd2: n_mnemonic = rvdec_pkg::MN_SLTI;
                    3'd3: n_mnemonic = rvdec_pkg::MN_SLTIU;
                    3'd4: n_mnemonic = rvdec_pkg::MN_XORI;
                    3'd6: n_mnemonic = rvdec_pkg::MN_ORI;
                    3'd7: n_mnemonic = rvdec_pkg::MN_ANDI;
                    3'd1: begin
                        n_imm      = {27'b0, rs2};
                        n_mnemonic = rvdec_pkg::MN_SLLI;
                        n_is_valid = (f7 == rvdec_pkg::F7_BASE);
                    end
                    default: begin
                        n_imm      = {27'b0, rs2};
                        n_mnemonic = (f7 == rvdec_pkg::F7_ALT) ? rvdec_pkg::MN_SRAI
                                                               : rvdec_pkg::MN_SRLI;
                        n_is_valid = (f7 == rvdec_pkg::F7_BASE) ||
                                     (f7 == rvdec_pkg::F7_ALT);
                    end
                endcase
            end
            rvdec_pkg::OPC_OP: begin
                n_is_valid = 1'b1;
                n_dest     = rd;
                n_src1     = rs1;
                n_src2     = rs2;
                priority if (f7 == rvdec_pkg::F7_BASE) begin
                    unique case (f3)
                        3'd0:    n_mnemonic = rvdec_pkg::MN_ADD;
                        3'd1:    n_mnemonic = rvdec_pkg::MN_SLL;
                        3'd2:    n_mnemonic = rvdec_pkg::MN_SLT;
                        3'd3:    n_mnemonic = rvdec_pkg::MN_SLTU;
                        3'd4:    n_mnemonic = rvdec_pkg::MN_XOR;
                        3'd5:    n_mnemonic = rvdec_pkg::MN_SRL;
                        3'd6:    n_mnemonic = rvdec_pkg::MN_OR;
                        default: n_mnemonic = rvdec_pkg::MN_AND;
                    endcase
                end else if (f7 == rvdec_pkg::F7_MULDIV) begin
                    unique case (f3)
                        3'd0:    n_mnemonic = rvdec_pkg::MN_MUL;
                        3'd1:    n_mnemonic = rvdec_pkg::MN_MULH;
                        3'd2:    n_mnemonic = rvdec_pkg::MN_MULHSU;
                        3'd3:    n_mnemonic = rvdec_pkg::MN_MULHU;
                        3'd4:    n_mnemonic = rvdec_pkg::MN_DIV;
                        3'd5:    n_mnemonic = rvdec_pkg::MN_DIVU;
                        3'd6:    n_mnemonic = rvdec_pkg::MN_REM;
                        default: n_mnemonic = rvdec_pkg::MN_REMU;
                    endcase
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd0) begin
                    n_mnemonic = rvdec_pkg::MN_SUB;
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd5) begin
                    n_mnemonic = rvdec_pkg::MN_SRA;
                end else begin
                    n_is_valid = 1'b0;
                end
            end
            rvdec_pkg::OPC_FENCE: begin
                priority if (f3 == 3'd0) begin
                    n_is_valid = 1'b1;
                    n_mnemonic = rvdec_pkg::MN_FENCE;
                    n_imm      = {24'b0, r_instr[27:20]};
                end else if (f3 == 3'd1) begin
                    n_is_valid = 1'b1;
                    n_mnemonic = rvdec_pkg::MN_FENCEI;
                end else begin
                    n_is_valid = 1'b0;
                end
            end
            rvdec_pkg::OPC_SYSTEM: begin
                if (f3 == 3'd0) begin
                    n_is_valid = (r_instr == rvdec_pkg::WORD_ECALL) ||
                                 (r_instr == rvdec_pkg::WORD_EBREAK);
                    n_mnemonic = (r_instr == rvdec_pkg::WORD_EBREAK) ? rvdec_pkg::MN_EBREAK
                                                                     : rvdec_pkg::MN_ECALL;
                end else begin
                    n_is_valid = 1'b1;
                    n_dest     = rd;
                    n_src1     = rs1;
                    n_imm      = {20'b0, r_instr[31:20]};
                    unique case (f3)
                        3'd1:    n_mnemonic = rvdec_pkg::MN_CSRRW;
                        3'd2:    n_mnemonic = rvdec_pkg::MN_CSRRS;
                        3'd3:    n_mnemonic = rvdec_pkg::MN_CSRRC;
                        3'd5:    n_mnemonic = rvdec_pkg::MN_CSRRWI;
                        3'd6:    n_mnemonic = rvdec_pkg::MN_CSRRSI;
                        3'd7:    n_mnemonic = rvdec_pkg::MN_CSRRCI;
                        default: n_is_valid = 1'b0;
                    endcase
                end
            end
            default: n_is_valid = 1'b0;
        endcase

        if (n_has_tgt) begin
            n_tgt = r_pc + n_imm;
        end

        // An unknown encoding reports every field as zero.
        if (!n_is_valid) begin
            n_mnemonic = rvdec_pkg::MN_LUI;
            n_dest     = '0;
            n_src1     = '0;
            n_src2     = '0;
            n_imm      = '0;
            n_has_tgt  = 1'b0;
            n_tgt      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_in_valid) begin
            r_mnemonic <= n_mnemonic;
            r_is_valid <= n_is_valid;
            r_dest     <= n_dest;
            r_src1     <= n_src1;
            r_src2     <= n_src2;
            r_imm      <= n_imm;
            r_has_tgt  <= n_has_tgt;
            r_tgt      <= n_tgt;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.mnemonic    = r_mnemonic;
    assign o_rsp.is_valid    = r_is_valid;
    assign o_rsp.dest_reg    = r_dest;
    assign o_rsp.src1_reg    = r_src1;
    assign o_rsp.src2_reg    = r_src2;
    assign o_rsp.immediate   = $signed(r_imm);
    assign o_rsp.has_target  = r_has_tgt;
    assign o_rsp.target_addr = r_tgt;

endmodule

@@ bench/rv32im_instruction_decoder_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the RV32IM instruction decoder top level.
// Depends on rvdec_pkg, the channel interfaces in rvdec_if.sv and the decoder RTL.
module rv32im_instruction_decoder_top_tb;
    import rvdec_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;
    localparam logic [29:0] INDEX_MAX = 30'h3fff_ffff;

    typedef struct packed {
        t_mnemonic   mnemonic;
        logic        is_valid;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [31:0] immediate;
        logic        has_target;
        logic [31:0] target_addr;
        logic [31:0] instr_word;
    } t_decoded;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_wdata;

    rvdec_req_if req_ch();
    rvdec_rsp_if rsp_ch();

    rv32im_instruction_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    logic [31:0] text_base_copy;
    t_decoded    pending_decodes[$];
    int          n_sent;
    int          n_checked;
    int          n_recognized;
    int          n_targets;
    int          n_bases;
    int          n_errors;
    int          quiet_cycles;
    t_rx_mode    rx_mode;
    int          rx_cycles_left;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Expected decode of one instruction word at the current text base.
    function automatic t_decoded predict_decode(logic [31:0] w, logic [29:0] idx);
        t_decoded    d;
        t_mnemonic   mn;
        logic        hit;
        logic        jump;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [4:0]  o_rd;
        logic [4:0]  o_rs1;
        logic [4:0]  o_rs2;
        logic [31:0] o_imm;
        logic [31:0] imm_i;

        opc = w[6:0];
        rd  = w[11:7];
        f3  = w[14:12];
        rs1 = w[19:15];
        rs2 = w[24:20];
        f7  = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        mn = MN_LUI;
        hit = 1'b0;
        jump = 1'b0;
        o_rd = '0;
        o_rs1 = '0;
        o_rs2 = '0;
        o_imm = '0;

        case (opc)
            OPC_LUI, OPC_AUIPC: begin
                hit = 1'b1;
                mn = (opc == OPC_LUI) ? MN_LUI : MN_AUIPC;
                o_rd = rd;
                o_imm = {12'd0, w[31:12]};
            end
            OPC_JAL: begin
                hit = 1'b1;
                mn = MN_JAL;
                jump = 1'b1;
                o_rd = rd;
                o_imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_JALR: begin
                if (f3 == 3'd0) begin
                    hit = 1'b1;
                    mn = MN_JALR;
                    o_rd = rd;
                    o_rs1 = rs1;
                    o_imm = imm_i;
                end
            end
            OPC_BRANCH: begin
                hit = 1'b1;
                jump = 1'b1;
                o_rs1 = rs1;
                o_rs2 = rs2;
                o_imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    3'd0: mn = MN_BEQ;
                    3'd1: mn = MN_BNE;
                    3'd4: mn = MN_BLT;
                    3'd5: mn = MN_BGE;
                    3'd6: mn = MN_BLTU;
                    3'd7: mn = MN_BGEU;
                    default: hit = 1'b0;
                endcase
            end
            OPC_LOAD: begin
                hit = 1'b1;
                o_rd = rd;
                o_rs1 = rs1;
                o_imm = imm_i;
                case (f3)
                    3'd0: mn = MN_LB;
                    3'd1: mn = MN_LH;
                    3'd2: mn = MN_LW;
                    3'd4: mn = MN_LBU;
                    3'd5: mn = MN_LHU;
                    default: hit = 1'b0;
                endcase
            end
            OPC_STORE: begin
                hit = 1'b1;
                o_rs1 = rs1;
                o_rs2 = rs2;
                o_imm = {{20{w[31]}}, w[31:25], w[11:7]};
                case (f3)
                    3'd0: mn = MN_SB;
                    3'd1: mn = MN_SH;
                    3'd2: mn = MN_SW;
                    default: hit = 1'b0;
                endcase
            end
            OPC_OPIMM: begin
                o_rd = rd;
                o_rs1 = rs1;
                if (f3 == 3'd1 || f3 == 3'd5) begin
                    // Shifts carry the shift amount in the rs2 position.
                    o_imm = {27'd0, rs2};
                    if (f7 == F7_BASE) begin
                        hit = 1'b1;
                        mn = (f3 == 3'd1) ? MN_SLLI : MN_SRLI;
                    end else if (f3 == 3'd5 && f7 == F7_ALT) begin
                        hit = 1'b1;
                        mn = MN_SRAI;
                    end
                end else begin
                    hit = 1'b1;
                    o_imm = imm_i;
                    case (f3)
                        3'd0: mn = MN_ADDI;
                        3'd2: mn = MN_SLTI;
                        3'd3: mn = MN_SLTIU;
                        3'd4: mn = MN_XORI;
                        3'd6: mn = MN_ORI;
                        default: mn = MN_ANDI;
                    endcase
                end
            end
            OPC_OP: begin
                o_rd = rd;
                o_rs1 = rs1;
                o_rs2 = rs2;
                if (f7 == F7_BASE) begin
                    hit = 1'b1;
                    case (f3)
                        3'd0: mn = MN_ADD;
                        3'd1: mn = MN_SLL;
                        3'd2: mn = MN_SLT;
                        3'd3: mn = MN_SLTU;
                        3'd4: mn = MN_XOR;
                        3'd5: mn = MN_SRL;
                        3'd6: mn = MN_OR;
                        default: mn = MN_AND;
                    endcase
                end else if (f7 == F7_MULDIV) begin
                    hit = 1'b1;
                    mn = t_mnemonic'(MN_MUL + f3);
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    hit = 1'b1;
                    mn = MN_SUB;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    hit = 1'b1;
                    mn = MN_SRA;
                end
            end
            OPC_FENCE: begin
                if (f3 == 3'd0) begin
                    hit = 1'b1;
                    mn = MN_FENCE;
                    o_imm = {24'd0, w[27:20]};
                end else if (f3 == 3'd1) begin
                    hit = 1'b1;
                    mn = MN_FENCEI;
                end
            end
            OPC_SYSTEM: begin
                if (f3 == 3'd0) begin
                    // Only the two exact environment call words are recognized.
                    if (w == WORD_ECALL) begin
                        hit = 1'b1;
                        mn = MN_ECALL;
                    end else if (w == WORD_EBREAK) begin
                        hit = 1'b1;
                        mn = MN_EBREAK;
                    end
                end else begin
                    hit = 1'b1;
                    o_rd = rd;
                    o_rs1 = rs1;
                    o_imm = {20'd0, w[31:20]};
                    case (f3)
                        3'd1: mn = MN_CSRRW;
                        3'd2: mn = MN_CSRRS;
                        3'd3: mn = MN_CSRRC;
                        3'd5: mn = MN_CSRRWI;
                        3'd6: mn = MN_CSRRSI;
                        3'd7: mn = MN_CSRRCI;
                        default: hit = 1'b0;
                    endcase
                end
            end
            default: hit = 1'b0;
        endcase

        d = '0;
        d.instr_word = w;
        if (hit) begin
            d.mnemonic = mn;
            d.is_valid = 1'b1;
            d.dest_reg = o_rd;
            d.src1_reg = o_rs1;
            d.src2_reg = o_rs2;
            d.immediate = o_imm;
            d.has_target = jump;
            d.target_addr = jump ? text_base_copy + {idx, 2'b00} + o_imm : 32'd0;
        end
        return d;
    endfunction

    // Builds a well-formed encoding of a mnemonic around random field content.
    function automatic logic [31:0] encode_mnemonic(t_mnemonic m, logic [31:0] r);
        logic [31:0] w;

        w = r;
        case (m)
            MN_LUI:    w[6:0] = OPC_LUI;
            MN_AUIPC:  w[6:0] = OPC_AUIPC;
            MN_JAL:    w[6:0] = OPC_JAL;
            MN_JALR:   begin w[6:0] = OPC_JALR; w[14:12] = 3'd0; end
            MN_BEQ:    begin w[6:0] = OPC_BRANCH; w[14:12] = 3'd0; end
            MN_BNE:    begin w[6:0] = OPC_BRANCH; w[14:12] = 3'd1; end
            MN_BLT:    begin w[6:0] = OPC_BRANCH; w[14:12] = 3'd4; end
            MN_BGE:    begin w[6:0] = OPC_BRANCH; w[14:12] = 3'd5; end
            MN_BLTU:   begin w[6:0] = OPC_BRANCH; w[14:12] = 3'd6; end
            MN_BGEU:   begin w[6:0] = OPC_BRANCH; w[14:12] = 3'd7; end
            MN_LB:     begin w[6:0] = OPC_LOAD; w[14:12] = 3'd0; end
            MN_LH:     begin w[6:0] = OPC_LOAD; w[14:12] = 3'd1; end
            MN_LW:     begin w[6:0] = OPC_LOAD; w[14:12] = 3'd2; end
            MN_LBU:    begin w[6:0] = OPC_LOAD; w[14:12] = 3'd4; end
            MN_LHU:    begin w[6:0] = OPC_LOAD; w[14:12] = 3'd5; end
            MN_SB:     begin w[6:0] = OPC_STORE; w[14:12] = 3'd0; end
            MN_SH:     begin w[6:0] = OPC_STORE; w[14:12] = 3'd1; end
            MN_SW:     begin w[6:0] = OPC_STORE; w[14:12] = 3'd2; end
            MN_ADDI:   begin w[6:0] = OPC_OPIMM; w[14:12] = 3'd0; end
            MN_SLTI:   begin w[6:0] = OPC_OPIMM; w[14:12] = 3'd2; end
            MN_SLTIU:  begin w[6:0] = OPC_OPIMM; w[14:12] = 3'd3; end
            MN_XORI:   begin w[6:0] = OPC_OPIMM; w[14:12] = 3'd4; end
            MN_ORI:    begin w[6:0] = OPC_OPIMM; w[14:12] = 3'd6; end
            MN_ANDI:   begin w[6:0] = OPC_OPIMM; w[14:12] = 3'd7; end
            MN_SLLI:   begin w[6:0] = OPC_OPIMM; w[14:12] = 3'd1; w[31:25] = F7_BASE; end
            MN_SRLI:   begin w[6:0] = OPC_OPIMM; w[14:12] = 3'd5; w[31:25] = F7_BASE; end
            MN_SRAI:   begin w[6:0] = OPC_OPIMM; w[14:12] = 3'd5; w[31:25] = F7_ALT; end
            MN_ADD:    begin w[6:0] = OPC_OP; w[14:12] = 3'd0; w[31:25] = F7_BASE; end
            MN_SUB:    begin w[6:0] = OPC_OP; w[14:12] = 3'd0; w[31:25] = F7_ALT; end
            MN_SLL:    begin w[6:0] = OPC_OP; w[14:12] = 3'd1; w[31:25] = F7_BASE; end
            MN_SLT:    begin w[6:0] = OPC_OP; w[14:12] = 3'd2; w[31:25] = F7_BASE; end
            MN_SLTU:   begin w[6:0] = OPC_OP; w[14:12] = 3'd3; w[31:25] = F7_BASE; end
            MN_XOR:    begin w[6:0] = OPC_OP; w[14:12] = 3'd4; w[31:25] = F7_BASE; end
            MN_SRL:    begin w[6:0] = OPC_OP; w[14:12] = 3'd5; w[31:25] = F7_BASE; end
            MN_SRA:    begin w[6:0] = OPC_OP; w[14:12] = 3'd5; w[31:25] = F7_ALT; end
            MN_OR:     begin w[6:0] = OPC_OP; w[14:12] = 3'd6; w[31:25] = F7_BASE; end
            MN_AND:    begin w[6:0] = OPC_OP; w[14:12] = 3'd7; w[31:25] = F7_BASE; end
            MN_MUL, MN_MULH, MN_MULHSU, MN_MULHU,
            MN_DIV, MN_DIVU, MN_REM, MN_REMU: begin
                w[6:0] = OPC_OP;
                w[14:12] = 3'(m - MN_MUL);
                w[31:25] = F7_MULDIV;
            end
            MN_FENCE:  begin w[6:0] = OPC_FENCE; w[14:12] = 3'd0; end
            MN_FENCEI: begin w[6:0] = OPC_FENCE; w[14:12] = 3'd1; end
            MN_ECALL:  w = WORD_ECALL;
            MN_EBREAK: w = WORD_EBREAK;
            MN_CSRRW:  begin w[6:0] = OPC_SYSTEM; w[14:12] = 3'd1; end
            MN_CSRRS:  begin w[6:0] = OPC_SYSTEM; w[14:12] = 3'd2; end
            MN_CSRRC:  begin w[6:0] = OPC_SYSTEM; w[14:12] = 3'd3; end
            MN_CSRRWI: begin w[6:0] = OPC_SYSTEM; w[14:12] = 3'd5; end
            MN_CSRRSI: begin w[6:0] = OPC_SYSTEM; w[14:12] = 3'd6; end
            default:   begin w[6:0] = OPC_SYSTEM; w[14:12] = 3'd7; end
        endcase
        return w;
    endfunction

    function automatic logic [29:0] pick_index();
        int sel;

        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return INDEX_MAX;
        return 30'($urandom());
    endfunction

    // Mostly well-formed encodings; the rest keeps a real opcode with random
    // funct bits or is plain noise.
    function automatic logic [31:0] pick_random_word();
        logic [6:0]  opcodes[11];
        logic [31:0] w;
        int          sel;

        opcodes = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD,
                    OPC_STORE, OPC_OPIMM, OPC_OP, OPC_FENCE, OPC_SYSTEM};
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            w = encode_mnemonic(t_mnemonic'($urandom_range(MN_LUI, MN_CSRRCI)), $urandom());
        end else if (sel < 92) begin
            w = $urandom();
            w[6:0] = opcodes[$urandom_range(0, 10)];
        end else begin
            w = $urandom();
        end
        return w;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want,
                                   logic [31:0] word);
        $display("ERROR: %s mismatch for word %h: got %h, expected %h",
                 field, word, got, want);
        n_errors++;
    endtask

    // Presents one request and waits until the decoder takes it. The valid
    // line stays high afterwards so back-to-back requests need no dip.
    task automatic send_instr(logic [31:0] w, logic [29:0] idx);
        @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.instr_word = w;
        req_ch.word_index = idx;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        pending_decodes.push_back(predict_decode(w, idx));
        n_sent++;
    endtask

    task automatic idle_gap(int cycles);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        req_ch.instr_word = $urandom();
        req_ch.word_index = 30'($urandom());
        repeat (cycles - 1)
            @(negedge i_clk);
    endtask

    task automatic drain_pending();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_text_base(logic [31:0] value);
        drain_pending();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        text_base_copy = value;
        n_bases++;
    endtask

    task automatic test_directed_encodings();
        logic [31:0] words[28];

        words = '{
            32'h0000_0000, 32'hffff_ffff,           // opcode zero and all-ones opcode
            32'hffff_ffb7, 32'h0000_0017,           // lui with all-ones upper bits, auipc
            32'h8000_006f, 32'h7fff_f0ef,           // jal most negative and most positive
            32'h800f_8067, 32'h0000_1067,           // jalr, jalr with nonzero funct3
            32'h8000_0063, 32'h7fff_ffe3,           // beq back, bgeu forward
            32'h0000_2063,                          // branch with unused funct3
            32'hfff0_2003, 32'h0000_3003,           // lw negative, unused load width
            32'hfe00_0fa3, 32'h0000_3023,           // sb at -1, unused store width
            32'h41f0_5013, 32'h0200_1013,           // srai by 31, slli with bad funct7
            32'h4000_1013,                          // slli with the arithmetic funct7
            32'h41ff_8fb3, 32'h0200_7033,           // sub, remu
            32'h4000_1033,                          // sll with the alternate funct7
            32'h8ff0_000f, 32'hffff_908f,           // fence with fm set, fence.i with junk
            32'h0000_0073, 32'h0010_0073,           // ecall, ebreak
            32'h0020_0073,                          // near-miss system word
            32'h0000_4073, 32'hffff_fff3            // csr funct3 of four, csrrci all ones
        };
        foreach (words[i]) begin
            case (i % 3)
                0: send_instr(words[i], '0);
                1: send_instr(words[i], INDEX_MAX);
                default: send_instr(words[i], 30'($urandom()));
            endcase
        end
    endtask

    // Jump and branch targets against extreme bases that can make the address sum wrap.
    task automatic test_text_base_extremes();
        logic [31:0] bases[3];
        t_mnemonic   mn;

        bases = '{32'hffff_ffff, 32'h8000_0000, 32'h0000_0004};
        foreach (bases[b]) begin
            set_text_base(bases[b]);
            repeat (12) begin
                mn = ($urandom_range(0, 2) == 0) ? MN_JAL
                                                 : t_mnemonic'($urandom_range(MN_BEQ, MN_BGEU));
                send_instr(encode_mnemonic(mn, $urandom()), pick_index());
            end
        end
    endtask

    task automatic test_random_stream();
        int remaining;
        int burst;

        for (int phase = 0; phase < 4; phase++) begin
            set_text_base($urandom());
            remaining = 120;
            while (remaining > 0) begin
                burst = $urandom_range(1, 16);
                if (burst > remaining)
                    burst = remaining;
                repeat (burst)
                    send_instr(pick_random_word(), pick_index());
                remaining -= burst;
                if ($urandom_range(0, 3) != 0)
                    idle_gap($urandom_range(1, 6));
            end
        end
    endtask

    // The receiver switches among stall patterns, picking a new one whenever its countdown runs out.
    always @(negedge i_clk) begin
        if (rx_cycles_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_cycles_left <= $urandom_range(20, 80);
        end else begin
            rx_cycles_left <= rx_cycles_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS:   rsp_ch.ready <= 1'b1;
            RX_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 99) < 70);
            RX_PERIODIC: rsp_ch.ready <= (rx_cycles_left % 4 != 0);
            default:     rsp_ch.ready <= ($urandom_range(0, 99) < 25);
        endcase
    end

    always @(posedge i_clk) begin
        t_decoded want;

        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            if (pending_decodes.size() == 0) begin
                report_mismatch("unexpected result", 32'(rsp_ch.mnemonic), '0, '0);
            end else begin
                want = pending_decodes.pop_front();
                n_checked++;
                if (want.is_valid)
                    n_recognized++;
                if (want.has_target)
                    n_targets++;
                if (rsp_ch.mnemonic !== want.mnemonic)
                    report_mismatch("mnemonic", 32'(rsp_ch.mnemonic), 32'(want.mnemonic),
                                    want.instr_word);
                if (rsp_ch.is_valid !== want.is_valid)
                    report_mismatch("is_valid", 32'(rsp_ch.is_valid), 32'(want.is_valid),
                                    want.instr_word);
                if (rsp_ch.dest_reg !== want.dest_reg)
                    report_mismatch("dest_reg", 32'(rsp_ch.dest_reg), 32'(want.dest_reg),
                                    want.instr_word);
                if (rsp_ch.src1_reg !== want.src1_reg)
                    report_mismatch("src1_reg", 32'(rsp_ch.src1_reg), 32'(want.src1_reg),
                                    want.instr_word);
                if (rsp_ch.src2_reg !== want.src2_reg)
                    report_mismatch("src2_reg", 32'(rsp_ch.src2_reg), 32'(want.src2_reg),
                                    want.instr_word);
                if (rsp_ch.immediate !== want.immediate)
                    report_mismatch("immediate", rsp_ch.immediate, want.immediate,
                                    want.instr_word);
                if (rsp_ch.has_target !== want.has_target)
                    report_mismatch("has_target", 32'(rsp_ch.has_target), 32'(want.has_target),
                                    want.instr_word);
                if (rsp_ch.target_addr !== want.target_addr)
                    report_mismatch("target_addr", rsp_ch.target_addr, want.target_addr,
                                    want.instr_word);
            end
        end
    end

    // Ends a hung run: too many cycles in a row with no request or result taken.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.instr_word = '0;
        req_ch.word_index = '0;
        rsp_ch.ready = 1'b0;
        rx_mode = RX_ALWAYS;
        rx_cycles_left = 0;
        quiet_cycles = 0;
        text_base_copy = '0;
        n_sent = 0;
        n_checked = 0;
        n_recognized = 0;
        n_targets = 0;
        n_bases = 1;
        n_errors = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_encodings();
        test_text_base_extremes();
        test_random_stream();

        drain_pending();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_decodes.size() != 0)
            report_mismatch("missing results", 32'(pending_decodes.size()), '0, '0);

        $display("Checked %0d decoded words: %0d recognized, %0d with a branch or jump target,",
                 n_checked, n_recognized, n_targets);
        $display("across %0d text base settings with random request gaps and result stalls.",
                 n_bases);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/rvdec_pkg.sv
src/rvdec_if.sv
src/rv32im_instruction_decoder_top.sv
bench/rv32im_instruction_decoder_top_tb.sv
